### hdl/tli_pkg.sv
// ----------------------------------------------------------------------------
// Table linear interpolator package
// Shared item types, row layout, command and status codes.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int VALUE_W     = 32;
    localparam int ROWS_W      = 7;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] abscissa;
        logic signed [VALUE_W-1:0] first_ordinate;
        logic signed [VALUE_W-1:0] second_ordinate;
        logic                      pick_first;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [1:0]                status;
        logic [ROWS_W-1:0]         rows_held;
    } t_out_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] abscissa;
        logic signed [VALUE_W-1:0] first_ordinate;
        logic signed [VALUE_W-1:0] second_ordinate;
    } t_row;

endpackage

### hdl/table_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// Table linear interpolator core
// Piecewise-linear interpolation over a breakpoint table held in RAM.
// ----------------------------------------------------------------------------
// Each input item carries a command: clear the table, append a row, or query
// one abscissa with a column select. Every item produces exactly one result
// item with the value, a status and the row count after the item.
// Input items are taken when i_in_valid is high and o_in_stall is low; the
// block stalls its input while it works on an item. Results are held in an
// output register until taken, so the block accepts a new item while a
// finished result waits; a second finished result waits, with the input stalled, until the first is taken.
// Clear, append and unknown commands go straight to the result. A query at or
// beyond either table end returns that end row's ordinate. An interior query
// scans rows for the bracketing pair (one row per cycle through the RAM read
// port), then takes three differences, 33 shift-add multiply steps and
// 65 restoring divide steps, all on one shared 35-bit adder. When the two
// bracketing abscissas are equal, the query returns the lower row's ordinate.
// Synchronous reset empties the table and drops any pending result; row
// storage is not cleared, since only appended rows are ever read.
// ----------------------------------------------------------------------------
module table_linear_interpolator_core #(
    parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tli_pkg::t_in_item   i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output tli_pkg::t_out_item  o_out_item,
    input  logic                i_out_stall
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ROW_W  = $bits(tli_pkg::t_row);
    localparam int MAG_W  = 33;
    localparam int PROD_W = 2 * MAG_W;
    localparam int ALU_W  = 35;
    localparam int STEP_W = 7;
    localparam logic [STEP_W-1:0] MUL_FIRST = STEP_W'(MAG_W - 1);
    localparam logic [STEP_W-1:0] DIV_FIRST = STEP_W'(PROD_W - 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CK_FIRST,
        S_CK_LAST,
        S_CK_ROW,
        S_DIFF_DY,
        S_DIFF_DX,
        S_DIFF_DD,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_FIX,
        S_DONE
    } t_state;

    function automatic logic [MAG_W-1:0] f_mag(input logic [MAG_W:0] v);
        logic [MAG_W:0] neg_v;
        neg_v = ~v + 1'b1;
        return v[MAG_W] ? neg_v[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic signed [31:0]     r_x, n_x;
    logic                   r_pick, n_pick;
    logic signed [31:0]     r_lo_x, n_lo_x;
    logic signed [31:0]     r_lo_y, n_lo_y;
    logic signed [31:0]     r_hi_x, n_hi_x;
    logic signed [31:0]     r_hi_y, n_hi_y;
    logic [MAG_W:0]         r_dy, n_dy;
    logic [MAG_W:0]         r_dx, n_dx;
    logic [MAG_W:0]         r_dd, n_dd;
    logic                   r_neg, n_neg;
    logic [MAG_W-1:0]       r_mcand, n_mcand;
    logic [MAG_W-1:0]       r_dvs, n_dvs;
    logic [PROD_W-1:0]      r_prod, n_prod;
    logic [MAG_W-1:0]       r_rem, n_rem;
    logic [STEP_W-1:0]      r_step, n_step;
    logic signed [31:0]     r_res_value, n_res_value;
    logic [1:0]             r_res_status, n_res_status;
    logic                   r_out_valid, n_out_valid;
    tli_pkg::t_out_item     r_out_item, n_out_item;

    logic                   in_acc;
    logic                   wr_en;
    logic                   rd_en;
    tli_pkg::t_row          wr_row;
    tli_pkg::t_row          rd_row;
    logic signed [31:0]     rd_y;
    logic [CNT_W-1:0]       cnt_m1;
    logic [ALU_W-1:0]       alu_a, alu_b, alu_y;
    logic                   alu_sub;
    logic                   qbit;
    logic                   sat_q;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign wr_row = '{abscissa:        i_in_item.abscissa,
                      first_ordinate:  i_in_item.first_ordinate,
                      second_ordinate: i_in_item.second_ordinate};
    assign rd_y   = r_pick ? rd_row.first_ordinate : rd_row.second_ordinate;
    assign cnt_m1 = r_count - 1'b1;
    assign rd_en  = (n_state == S_CK_FIRST) || (n_state == S_CK_LAST) ||
                    (n_state == S_CK_ROW);

    tli_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (wr_row),
        .i_re    (rd_en),
        .i_raddr (n_idx),
        .o_rdata (rd_row)
    );

    // The one shared adder serves the differences, multiply, divide and final sum.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (r_state)
            S_DIFF_DY: begin
                alu_a = {{(ALU_W-32){r_hi_y[31]}}, r_hi_y};
                alu_b = {{(ALU_W-32){r_lo_y[31]}}, r_lo_y};
            end
            S_DIFF_DX: begin
                alu_a = {{(ALU_W-32){r_x[31]}}, r_x};
                alu_b = {{(ALU_W-32){r_lo_x[31]}}, r_lo_x};
            end
            S_DIFF_DD: begin
                alu_a = {{(ALU_W-32){r_hi_x[31]}}, r_hi_x};
                alu_b = {{(ALU_W-32){r_lo_x[31]}}, r_lo_x};
            end
            S_MUL: begin
                alu_sub = 1'b0;
                alu_a   = {2'b00, r_prod[PROD_W-1:MAG_W]};
                alu_b   = r_prod[0] ? {2'b00, r_mcand} : '0;
            end
            S_DIV: begin
                alu_a = {1'b0, r_rem, r_prod[PROD_W-2]};
                alu_b = {2'b00, r_dvs};
            end
            S_FIX: begin
                alu_sub = r_neg;
                alu_a   = {{(ALU_W-32){r_lo_y[31]}}, r_lo_y};
                alu_b   = {1'b0, r_prod[MAG_W:0]};
            end
            default: begin
                alu_sub = 1'b1;
            end
        endcase
    end

    assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
    assign qbit  = !alu_y[ALU_W-1];
    assign sat_q = (|r_prod[PROD_W-2:MAG_W+1]) || (r_prod[MAG_W] && (|r_prod[MAG_W-1:0]));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_x          = r_x;
        n_pick       = r_pick;
        n_lo_x       = r_lo_x;
        n_lo_y       = r_lo_y;
        n_hi_x       = r_hi_x;
        n_hi_y       = r_hi_y;
        n_dy         = r_dy;
        n_dx         = r_dx;
        n_dd         = r_dd;
        n_neg        = r_neg;
        n_mcand      = r_mcand;
        n_dvs        = r_dvs;
        n_prod       = r_prod;
        n_rem        = r_rem;
        n_step       = r_step;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        wr_en        = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_x          = i_in_item.abscissa;
                    n_pick       = i_in_item.pick_first;
                    n_res_value  = '0;
                    n_res_status = tli_pkg::ST_OK;
                    n_state      = S_DONE;
                    case (i_in_item.command)
                        tli_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        tli_pkg::CMD_APPEND: begin
                            if (r_count < CNT_W'(TABLE_DEPTH)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_res_status = tli_pkg::ST_FULL;
                            end
                        end
                        tli_pkg::CMD_QUERY: begin
                            if (r_count == '0) begin
                                n_res_status = tli_pkg::ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_CK_FIRST;
                            end
                        end
                        default: begin
                            n_res_status = tli_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_CK_FIRST: begin
                if (r_x <= rd_row.abscissa) begin
                    n_res_value = rd_y;
                    n_state     = S_DONE;
                end else begin
                    n_lo_x  = rd_row.abscissa;
                    n_lo_y  = rd_y;
                    n_idx   = cnt_m1[IDX_W-1:0];
                    n_state = S_CK_LAST;
                end
            end
            S_CK_LAST: begin
                if (r_x >= rd_row.abscissa) begin
                    n_res_value = rd_y;
                    n_state     = S_DONE;
                end else begin
                    n_idx   = IDX_W'(1);
                    n_state = S_CK_ROW;
                end
            end
            S_CK_ROW: begin
                if (r_x <= rd_row.abscissa) begin
                    n_hi_x  = rd_row.abscissa;
                    n_hi_y  = rd_y;
                    n_state = S_DIFF_DY;
                end else begin
                    n_lo_x = rd_row.abscissa;
                    n_lo_y = rd_y;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_DIFF_DY: begin
                n_dy    = alu_y[MAG_W:0];
                n_state = S_DIFF_DX;
            end
            S_DIFF_DX: begin
                n_dx    = alu_y[MAG_W:0];
                n_state = S_DIFF_DD;
            end
            S_DIFF_DD: begin
                n_dd    = alu_y[MAG_W:0];
                n_state = S_SETUP;
            end
            S_SETUP: begin
                if (r_dd == '0) begin
                    n_res_value = r_lo_y;
                    n_state     = S_DONE;
                end else begin
                    n_prod  = {{MAG_W{1'b0}}, f_mag(r_dx)};
                    n_mcand = f_mag(r_dy);
                    n_dvs   = f_mag(r_dd);
                    n_neg   = r_dy[MAG_W] ^ r_dx[MAG_W] ^ r_dd[MAG_W];
                    n_step  = MUL_FIRST;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod = {alu_y[MAG_W:0], r_prod[MAG_W-1:1]};
                if (r_step == '0) begin
                    n_rem   = '0;
                    n_step  = DIV_FIRST;
                    n_state = S_DIV;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_DIV: begin
                n_rem  = qbit ? alu_y[MAG_W-1:0] : alu_a[MAG_W-1:0];
                n_prod = {1'b0, r_prod[PROD_W-3:0], qbit};
                if (r_step == '0) begin
                    n_state = S_FIX;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_FIX: begin
                if (sat_q) begin
                    n_res_value = r_neg ? tli_pkg::VALUE_MIN : tli_pkg::VALUE_MAX;
                end else if ((alu_y[ALU_W-1:31] == '0) || (alu_y[ALU_W-1:31] == '1)) begin
                    n_res_value = alu_y[31:0];
                end else begin
                    n_res_value = alu_y[ALU_W-1] ? tli_pkg::VALUE_MIN : tli_pkg::VALUE_MAX;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{result_value: r_res_value,
                                    status:       r_res_status,
                                    rows_held:    tli_pkg::ROWS_W'(r_count)};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_x          <= n_x;
        r_pick       <= n_pick;
        r_lo_x       <= n_lo_x;
        r_lo_y       <= n_lo_y;
        r_hi_x       <= n_hi_x;
        r_hi_y       <= n_hi_y;
        r_dy         <= n_dy;
        r_dx         <= n_dx;
        r_dd         <= n_dd;
        r_neg        <= n_neg;
        r_mcand      <= n_mcand;
        r_dvs        <= n_dvs;
        r_prod       <= n_prod;
        r_rem        <= n_rem;
        r_step       <= n_step;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_item   <= n_out_item;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("Row count exceeds the table depth.");

    a_search_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CK_ROW) |-> (CNT_W'(r_idx) < r_count))
        else $error("Row search ran past the last stored row.");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == tli_pkg::ST_EMPTY)) |->
        (o_out_item.rows_held == '0))
        else $error("Empty-table status reported with rows held.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE && !r_out_valid) |=> !($rose(o_out_valid)))
        else $error("Result item appeared without a finished item.");

endmodule

### hdl/tli_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = tli_pkg::TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
